// File: hw/rtl/oml_pkg.sv
// Package for the overwriting message log: sizes, record layout and the
// command and status groups between the controller and the datapath.
// No dependencies; every other file of the block but oml_ram uses it.
package oml_pkg;

  // Number of record slots in the log storage.
  localparam int LOG_DEPTH   = 16;
  // Most results that one read-back request may return.
  localparam int MAX_RESULTS = 16;

  // Slot index width and the width of a count that can hold LOG_DEPTH itself.
  localparam int IDX_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CNT_W = $clog2(LOG_DEPTH + 1);

  // Field widths fixed by the interface.
  localparam int PAYLOAD_W = 64;
  localparam int TIME_W    = 17;
  localparam int SERIAL_W  = 32;
  localparam int COUNT_W   = 5;
  localparam int DEPTH_W   = 5;

  // Depth register after reset, already clamped to the storage size.
  localparam int DEPTH_RESET_INT = (16 > LOG_DEPTH) ? LOG_DEPTH : 16;
  localparam logic [CNT_W-1:0] DEPTH_RESET = CNT_W'(DEPTH_RESET_INT);

  // Request mode code that saves a record; the other code reads back.
  localparam logic MODE_SAVE = 1'b0;

  // One stored record.
  typedef struct packed {
    logic [PAYLOAD_W-1:0] payload;
    logic [TIME_W-1:0]    rtime;
    logic [SERIAL_W-1:0]  serial;
  } record_t;

  localparam int RECORD_W = $bits(record_t);

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic save;        // store the request's record and queue its echo
    logic start_read;  // load the read pointer and the record count
    logic issue;       // read the next record of a read-back
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic stage_free;  // the result staging slot can take a record this cycle
    logic k_zero;      // the clamped read-back count of the request is zero
    logic rem_one;     // the record about to be read is the final one
  } status_t;

endpackage

// File: hw/rtl/oml_if.sv
// Valid/ready channel interfaces for the request and result sides of the
// overwriting message log. Depends on oml_pkg for the field widths.
interface oml_in_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [oml_pkg::PAYLOAD_W-1:0]  payload;
  logic [oml_pkg::TIME_W-1:0]     receipt_time;
  logic [oml_pkg::COUNT_W-1:0]    count_requested;

  modport source (output valid, mode, payload, receipt_time, count_requested,
                  input ready);
  modport sink   (input valid, mode, payload, receipt_time, count_requested,
                  output ready);
endinterface

interface oml_out_if;
  logic                           valid;
  logic                           ready;
  logic [oml_pkg::PAYLOAD_W-1:0]  out_payload;
  logic [oml_pkg::TIME_W-1:0]     out_time;
  logic [oml_pkg::SERIAL_W-1:0]   serial_number;
  logic                           last;

  modport source (output valid, out_payload, out_time, serial_number, last,
                  input ready);
  modport sink   (input valid, out_payload, out_time, serial_number, last,
                  output ready);
endinterface

// File: hw/rtl/oml_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module oml_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                  wdata,
  input  logic                              re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is enabled.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/oml_ctrl.sv
// Controller of the overwriting message log: takes requests and sequences
// the reads of a read-back. Depends on oml_pkg and oml_if.
module oml_ctrl (
  input  logic              clk,
  input  logic              rst,
  oml_in_if.sink            request,
  input  oml_pkg::status_t  st,
  output oml_pkg::cmd_t     cmd
);

  oml_pkg::state_t state;
  oml_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oml_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, commands and request acceptance.
  always_comb begin
    state_next    = state;
    cmd           = '0;
    request.ready = 1'b0;
    case (state)
      oml_pkg::ST_IDLE: begin
        // A request is taken whenever the staging slot can take a record.
        request.ready = st.stage_free;
        if (request.valid && st.stage_free) begin
          if (request.mode == oml_pkg::MODE_SAVE) begin
            cmd.save = 1'b1;
          end else if (!st.k_zero) begin
            cmd.start_read = 1'b1;
            state_next     = oml_pkg::ST_READ;
          end
        end
      end
      oml_pkg::ST_READ: begin
        // One record read per cycle while the staging slot drains.
        if (st.stage_free) begin
          cmd.issue = 1'b1;
          if (st.rem_one) begin
            state_next = oml_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = oml_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/oml_datapath.sv
// Datapath of the overwriting message log: pointers and counts, the record
// RAM, the result staging slot and the output register.
// Depends on oml_pkg, oml_if and oml_ram.
module oml_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [oml_pkg::DEPTH_W-1:0]    cfg_wdata,
  input  logic [oml_pkg::PAYLOAD_W-1:0]  in_payload,
  input  logic [oml_pkg::TIME_W-1:0]     in_time,
  input  logic [oml_pkg::COUNT_W-1:0]    in_count,
  input  oml_pkg::cmd_t                  cmd,
  output oml_pkg::status_t               st,
  oml_out_if.source                      result
);

  localparam int IDX_W = oml_pkg::IDX_W;
  localparam int CNT_W = oml_pkg::CNT_W;

  // Log state.
  logic [CNT_W-1:0]             act_depth;
  logic [IDX_W-1:0]             newest_idx;
  logic [CNT_W-1:0]             fill;
  logic [oml_pkg::SERIAL_W-1:0] newest_serial;

  // Read-back sequencing.
  logic [IDX_W-1:0]             rd_idx;
  logic [CNT_W-1:0]             rem;

  // Staging slot ahead of the output register.
  logic                         pend;
  logic                         pend_echo;
  logic                         pend_last;
  oml_pkg::record_t             echo_rec;

  // Output register.
  logic                         ovalid;
  oml_pkg::record_t             orec;
  logic                         olast;

  oml_pkg::record_t             wr_rec;
  oml_pkg::record_t             ram_rec;
  logic [oml_pkg::RECORD_W-1:0] ram_rdata;
  logic [IDX_W-1:0]             save_slot;
  logic [IDX_W-1:0]             rd_idx_next;
  logic [CNT_W-1:0]             depth_clamped;
  logic [CNT_W-1:0]             k_sel;
  logic                         load_now;

  // Depth clamping for a register write.
  always_comb begin
    if (cfg_wdata == '0) begin
      depth_clamped = CNT_W'(1);
    end else if (int'(cfg_wdata) > oml_pkg::LOG_DEPTH) begin
      depth_clamped = CNT_W'(oml_pkg::LOG_DEPTH);
    end else begin
      depth_clamped = CNT_W'(cfg_wdata);
    end
  end

  // Slot of a new record: one past the newest, wrapping at the depth in use.
  always_comb begin
    if (fill == '0) begin
      save_slot = '0;
    end else if (CNT_W'(newest_idx) + CNT_W'(1) == act_depth) begin
      save_slot = '0;
    end else begin
      save_slot = newest_idx + IDX_W'(1);
    end
  end

  // Read-back count clamped to the stored records and the result limit.
  always_comb begin
    int k_full;
    k_full = int'(in_count);
    if (k_full > int'(fill)) begin
      k_full = int'(fill);
    end
    if (k_full > oml_pkg::MAX_RESULTS) begin
      k_full = oml_pkg::MAX_RESULTS;
    end
    k_sel = CNT_W'(k_full);
  end

  // Read pointer steps towards older records, wrapping below slot zero.
  always_comb begin
    if (rd_idx == '0) begin
      rd_idx_next = IDX_W'(act_depth - CNT_W'(1));
    end else begin
      rd_idx_next = rd_idx - IDX_W'(1);
    end
  end

  // Record written on a save.
  always_comb begin
    wr_rec.payload = in_payload;
    wr_rec.rtime   = in_time;
    wr_rec.serial  = newest_serial + oml_pkg::SERIAL_W'(1);
  end

  // The staging slot moves on when the output register is empty or drains.
  assign load_now      = pend && (!ovalid || result.ready);
  assign st.stage_free = !pend || load_now;
  assign st.k_zero     = (k_sel == '0);
  assign st.rem_one    = (rem == CNT_W'(1));

  // Record storage.
  oml_ram #(
    .WIDTH (oml_pkg::RECORD_W),
    .DEPTH (oml_pkg::LOG_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.save),
    .waddr (save_slot),
    .wdata (wr_rec),
    .re    (cmd.issue),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  assign ram_rec = oml_pkg::record_t'(ram_rdata);

  // Log pointers, fill count and serial counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      act_depth     <= oml_pkg::DEPTH_RESET;
      newest_idx    <= '0;
      fill          <= '0;
      newest_serial <= '0;
    end else if (cfg_we) begin
      act_depth  <= depth_clamped;
      newest_idx <= '0;
      fill       <= '0;
    end else if (cmd.save) begin
      newest_idx    <= save_slot;
      newest_serial <= wr_rec.serial;
      if (fill < act_depth) begin
        fill <= fill + CNT_W'(1);
      end
    end
  end

  // Read-back pointer and remaining count.
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (cmd.start_read) begin
      rem <= k_sel;
    end else if (cmd.issue) begin
      rem <= rem - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_read) begin
      rd_idx <= newest_idx;
    end else if (cmd.issue) begin
      rd_idx <= rd_idx_next;
    end
  end

  // Staging slot: holds either a save echo or a record read from the RAM.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (cmd.save || cmd.issue) begin
      pend <= 1'b1;
    end else if (load_now) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.save) begin
      echo_rec  <= wr_rec;
      pend_echo <= 1'b1;
      pend_last <= 1'b1;
    end else if (cmd.issue) begin
      pend_echo <= 1'b0;
      pend_last <= (rem == CNT_W'(1));
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (load_now) begin
      ovalid <= 1'b1;
    end else if (result.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_now) begin
      orec  <= pend_echo ? echo_rec : ram_rec;
      olast <= pend_last;
    end
  end

  assign result.valid         = ovalid;
  assign result.out_payload   = orec.payload;
  assign result.out_time      = orec.rtime;
  assign result.serial_number = orec.serial;
  assign result.last          = olast;

`ifndef SYNTHESIS
  // The fill count never goes beyond the depth in use.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= act_depth)
    else $error("fill count above depth in use");

  // The newest slot lies inside the depth in use.
  a_newest_bound: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(newest_idx) < act_depth)
    else $error("newest slot outside depth in use");

  // A record read is only issued while records of the read-back remain.
  a_issue_rem: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> rem != '0)
    else $error("record read with no records remaining");

  // The staging slot is never overwritten before it has moved on.
  a_stage_overrun: assert property (@(posedge clk) disable iff (rst)
    (cmd.save || cmd.issue) |-> (!pend || load_now))
    else $error("staging slot overwritten");

  // After the final read of a read-back the staged record carries last.
  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    (cmd.issue && rem == CNT_W'(1)) |=> (pend && pend_last))
    else $error("final record not marked last");
`endif

endmodule

// File: hw/rtl/overwriting_message_log_unit.sv
// Top level of the overwriting message log: a circular record store that
// overwrites its oldest record. Depends on oml_pkg, oml_if, oml_ctrl and
// oml_datapath.
//
//   Channel   Direction  Handshake      Contents
//   request   in         valid/ready    mode, payload, receipt_time, count_requested
//   result    out        valid/ready    out_payload, out_time, serial_number, last
//   config    in         cfg_we         cfg_wdata: depth in use
//
// A save request writes its record to the record RAM; its echo passes through the
// staging slot and the output register to result. A read-back of K records first
// loads the read pointer and the record count, then reads one record per cycle while
// the staging slot can take it, set by the single registered read port of the RAM.
// Reset is synchronous; the record RAM needs no clearing, as only written
// slots are read. A stalled result holds in the output register while one
// more record waits in the staging slot; beyond that the block stalls.
module overwriting_message_log_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [oml_pkg::DEPTH_W-1:0]  cfg_wdata,
  oml_in_if.sink                       request,
  oml_out_if.source                    result
);

  oml_pkg::cmd_t    cmd;
  oml_pkg::status_t st;

  // Request handling and read-back sequencing.
  oml_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .st      (st),
    .cmd     (cmd)
  );

  // Storage, pointers and result path.
  oml_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_payload (request.payload),
    .in_time    (request.receipt_time),
    .in_count   (request.count_requested),
    .cmd        (cmd),
    .st         (st),
    .result     (result)
  );

endmodule

// File: bench/tb_overwriting_message_log_unit.sv
// Testbench for overwriting_message_log_unit: directed and random save and read-back
// requests checked against a behavioural model of the circular log.
// Depends on oml_pkg and on the oml_in_if and oml_out_if interfaces of the RTL.
module tb_overwriting_message_log_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import oml_pkg::*;

  localparam logic MODE_SHOW       = ~MODE_SAVE;
  localparam int   DRAIN_CYCLES    = 8;
  localparam int   HOLD_OFF_CYCLES = 80;
  localparam int   REPORT_LIMIT    = 10;
  localparam int   RUN_LIMIT_NS    = 500_000;
  localparam int   PHASE_ITEMS     = 27;

  // One result as the log should return it.
  typedef struct packed {
    logic [PAYLOAD_W-1:0] payload;
    logic [TIME_W-1:0]    rtime;
    logic [SERIAL_W-1:0]  serial;
    logic                 last;
  } log_result_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [DEPTH_W-1:0]   cfg_wdata;

  oml_in_if  req_if ();
  oml_out_if res_if ();

  overwriting_message_log_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .request   (req_if),
    .result    (res_if)
  );

  // Model of the log contents and the depth register.
  record_t            log_slots [LOG_DEPTH];
  logic [DEPTH_W-1:0] log_depth_reg;
  int unsigned        log_fill;
  int unsigned        log_newest;
  logic [SERIAL_W-1:0] log_serial;
  log_result_t        records_due [$];

  int  fail_count      = 0;
  int  requests_taken  = 0;
  int  results_checked = 0;
  int  depth_writes    = 0;
  int  burst_left      = 0;
  bit  sender_steady   = 1'b0;
  bit  hold_off_pending = 1'b0;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Depth as the log applies it: zero acts as one, oversize as the full store.
  function automatic int unsigned active_log_depth();
    if (log_depth_reg == '0) return 1;
    if (log_depth_reg > LOG_DEPTH) return LOG_DEPTH;
    return log_depth_reg;
  endfunction

  // Apply one accepted request to the model and queue the records it returns.
  task automatic track_log_request(input logic m, input logic [PAYLOAD_W-1:0] p,
                                   input logic [TIME_W-1:0] t,
                                   input logic [COUNT_W-1:0] k);
    int unsigned depth;
    int unsigned slot;
    int unsigned n;
    depth = active_log_depth();
    if (m == MODE_SAVE) begin
      slot = (log_fill == 0) ? 0 : (log_newest + 1) % depth;
      log_serial = log_serial + 1'b1;
      log_slots[slot] = '{payload: p, rtime: t, serial: log_serial};
      log_newest = slot;
      if (log_fill < depth) log_fill++;
      records_due.push_back('{payload: p, rtime: t, serial: log_serial, last: 1'b1});
    end else begin
      // The count is clamped to what is stored and to the result limit, newest record first.
      n = k;
      if (n > log_fill) n = log_fill;
      if (n > MAX_RESULTS) n = MAX_RESULTS;
      for (int unsigned i = 0; i < n; i++) begin
        slot = (log_newest + depth - i) % depth;
        records_due.push_back('{payload: log_slots[slot].payload,
                                rtime:   log_slots[slot].rtime,
                                serial:  log_slots[slot].serial,
                                last:    (i + 1 == n)});
      end
    end
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
  endtask

  // Offer one request; the sender works in bursts with random gaps between them.
  task automatic send_request(input logic m, input logic [PAYLOAD_W-1:0] p,
                              input logic [TIME_W-1:0] t,
                              input logic [COUNT_W-1:0] k);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (sender_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        req_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    req_if.valid           <= 1'b1;
    req_if.mode            <= m;
    req_if.payload         <= p;
    req_if.receipt_time    <= t;
    req_if.count_requested <= k;
    do @(posedge clk); while (!req_if.ready);
    track_log_request(m, p, t, k);
    requests_taken++;
  endtask

  task automatic send_save(input logic [PAYLOAD_W-1:0] p, input logic [TIME_W-1:0] t);
    send_request(MODE_SAVE, p, t, COUNT_W'($urandom));
  endtask

  task automatic send_show(input logic [COUNT_W-1:0] k);
    send_request(MODE_SHOW, {$urandom, $urandom}, TIME_W'($urandom), k);
  endtask

  // Stop offering requests and wait until every expected record has come back.
  task automatic wait_for_drain();
    @(negedge clk);
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (records_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the depth register while the log is idle; this also empties the log.
  task automatic write_depth(input logic [DEPTH_W-1:0] value);
    wait_for_drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    log_depth_reg = value;
    log_fill      = 0;
    log_newest    = 0;
    @(negedge clk);
    cfg_we <= 1'b0;
    depth_writes++;
  endtask

  // Read-backs of an empty log, with and without a count, return nothing.
  task automatic test_empty_log();
    send_show(COUNT_W'(5));
    send_show('0);
    wait_for_drain();
  endtask

  // Extreme payloads and times, then read-backs of zero, some and too many.
  task automatic test_field_extremes();
    send_save('0, '0);
    send_save('1, TIME_W'(86399));
    send_save({16{4'hA}}, '1);
    send_save({16{4'h5}}, TIME_W'(17'h10000));
    send_save({$urandom, $urandom}, TIME_W'(1));
    send_show('0);
    send_show(COUNT_W'(1));
    send_show(COUNT_W'(3));
    send_show('1);
    send_show(COUNT_W'(16));
    wait_for_drain();
  endtask

  // Out-of-range depths, emptying on a write, and overwrite with a small depth.
  task automatic test_depth_register();
    write_depth('0);
    send_save({$urandom, $urandom}, TIME_W'($urandom));
    send_save({$urandom, $urandom}, TIME_W'($urandom));
    send_show(COUNT_W'(3));
    write_depth('1);
    send_show(COUNT_W'(4));
    send_save({$urandom, $urandom}, TIME_W'($urandom));
    send_show(COUNT_W'(2));
    write_depth(DEPTH_W'(3));
    repeat (5) send_save({$urandom, $urandom}, TIME_W'($urandom));
    send_show('1);
    wait_for_drain();
  endtask

  // The result side holds off for a long stretch while saves keep coming, so the
  // log fills up and stalls its request side; then the sender waits for the drain.
  task automatic test_result_backpressure();
    write_depth(DEPTH_W'(16));
    sender_steady = 1'b1;
    @(posedge clk);
    hold_off_pending = 1'b1;
    repeat (29) send_save({$urandom, $urandom}, TIME_W'($urandom_range(0, 131071)));
    send_show(COUNT_W'(16));
    sender_steady = 1'b0;
    wait_for_drain();
  endtask

  // Random mix of saves and read-backs over several depth settings.
  task automatic test_random_traffic();
    logic [DEPTH_W-1:0] phase_depths [8];
    int unsigned        roll;
    int unsigned        depth;
    phase_depths = '{DEPTH_W'(16), DEPTH_W'(1), DEPTH_W'(17), DEPTH_W'(5),
                     DEPTH_W'(0), DEPTH_W'(31), DEPTH_W'($urandom_range(2, 15)),
                     DEPTH_W'(16)};
    foreach (phase_depths[ph]) begin
      write_depth(phase_depths[ph]);
      sender_steady = (ph == 3);
      depth = active_log_depth();
      repeat (PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 60)
          send_save({$urandom, $urandom}, TIME_W'($urandom_range(0, 131071)));
        else if (roll < 85)
          send_show(COUNT_W'($urandom_range(1, (depth + 2 > 31) ? 31 : depth + 2)));
        else if (roll < 92)
          send_show('0);
        else
          send_show(COUNT_W'($urandom_range(0, 31)));
      end
    end
    sender_steady = 1'b0;
    wait_for_drain();
  endtask

  // Result ready follows its own pattern of runs, plus one long hold-off on demand.
  initial begin : result_ready_pattern
    int unsigned run_left;
    int unsigned hold_left;
    logic        run_level;
    run_left  = 0;
    hold_left = 0;
    run_level = 1'b0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_level = !run_level;
          if (run_level)
            run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
          else
            run_left = $urandom_range(1, 4);
        end
        run_left--;
        res_if.ready <= run_level;
      end
    end
  end

  // Compare every returned record with the oldest one still expected.
  always @(posedge clk) begin : check_results
    log_result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      results_checked++;
      if (records_due.size() == 0) begin
        note_failure($sformatf("unexpected result: payload %h time %0d serial %0d last %0b",
                               res_if.out_payload, res_if.out_time,
                               res_if.serial_number, res_if.last));
      end else begin
        want = records_due.pop_front();
        if (res_if.out_payload !== want.payload || res_if.out_time !== want.rtime ||
            res_if.serial_number !== want.serial || res_if.last !== want.last) begin
          note_failure($sformatf({"result mismatch: expected payload %h time %0d ",
                                  "serial %0d last %0b, got payload %h time %0d ",
                                  "serial %0d last %0b"},
                                 want.payload, want.rtime, want.serial, want.last,
                                 res_if.out_payload, res_if.out_time,
                                 res_if.serial_number, res_if.last));
        end
      end
    end
  end

  // Main sequence: reset, then each test in turn.
  initial begin
    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_wdata              = '0;
    req_if.valid           = 1'b0;
    req_if.mode            = MODE_SAVE;
    req_if.payload         = '0;
    req_if.receipt_time    = '0;
    req_if.count_requested = '0;
    log_depth_reg          = DEPTH_W'(16);
    log_fill               = 0;
    log_newest             = 0;
    log_serial             = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    test_empty_log();
    test_field_extremes();
    test_depth_register();
    test_result_backpressure();
    test_random_traffic();
    wait_for_drain();

    $display("Checked %0d records from %0d requests over %0d depth settings,",
             results_checked, requests_taken, depth_writes);
    $display("including a long result stall and overwrite at depths one to sixteen.");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d failures", fail_count);
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Run stopped by the watchdog with %0d records outstanding", records_due.size());
    $display("simulation failed");
    $finish;
  end

endmodule

// File: overwriting_message_log_unit.f
hw/rtl/oml_pkg.sv
hw/rtl/oml_if.sv
hw/rtl/oml_ram.sv
hw/rtl/oml_ctrl.sv
hw/rtl/oml_datapath.sv
hw/rtl/overwriting_message_log_unit.sv
bench/tb_overwriting_message_log_unit.sv
